[sv/bpe_pkg.sv]
`default_nettype none
package bpe_pkg;

  localparam int LEVEL_MAX_DEF = 64;
  localparam logic [6:0] LEVEL_RESET = 7'd12;

  localparam int NUM_W   = 23;  // i*65536 + n/2
  localparam int DEN_W   = 7;
  localparam int WT_W    = 17;  // Bernstein weight, Q0.16 up to 1.0
  localparam int CW_W    = 18;  // signed derivative coefficient
  localparam int ACC_W   = 56;
  localparam int TAN_W   = 24;
  localparam int COORD_W = 16;
  localparam int NRM_W   = 24;

  localparam logic [4:0] ACC_LAST = 5'd17;  // 16 issues plus two pipe stages
  localparam logic [4:0] ACC_PTS  = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_W1,
    ST_W2,
    ST_ACC,
    ST_X1,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       in_ready;
    logic       div_go;
    logic       w1;
    logic       w2;
    logic       issue;
    logic [3:0] idx;
    logic       x1;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic eval_req;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[sv/bpe_if.sv]
`default_nettype none
interface bpe_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [3:0]         point_slot;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [6:0]         grid_i;
  logic [6:0]         grid_j;

  modport source (output valid, operation, point_slot, coord_x, coord_y, coord_z,
                  grid_i, grid_j, input ready);
  modport sink (input valid, operation, point_slot, coord_x, coord_y, coord_z,
                grid_i, grid_j, output ready);
endinterface

interface bpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [23:0] norm_x;
  logic signed [23:0] norm_y;
  logic signed [23:0] norm_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [12:0]        vertex_index;
  logic               closes_quad;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u,
                  tex_v, vertex_index, closes_quad, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u,
                tex_v, vertex_index, closes_quad, output ready);
endinterface
`default_nettype wire

[sv/bpe_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module bpe_div
  import bpe_pkg::*;
#(
  parameter int NW = NUM_W,
  parameter int DW = DEN_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r;
  logic [DW:0]      rem_sh;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(NW);
      quo_nxt = num;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[NW-2:0], ge};
      rem_nxt = ge ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = cnt_r != '0;
  assign quo  = quo_r;
endmodule
`default_nettype wire

[sv/bpe_ctrl.sv]
`default_nettype none
module bpe_ctrl
  import bpe_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire status_t st,
  output cmd_t         cmd
);
  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: if (st.eval_req) state_nxt = ST_DIV;
      ST_DIV:  if (!st.div_busy) state_nxt = ST_W1;
      ST_W1:   state_nxt = ST_W2;
      ST_W2: begin
        state_nxt = ST_ACC;
        cnt_nxt   = '0;
      end
      ST_ACC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ACC_LAST) state_nxt = ST_X1;
      end
      ST_X1:   state_nxt = ST_OUT;
      ST_OUT:  if (st.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.idx      = cnt_r[3:0];
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.div_go   = st.eval_req;
      end
      ST_W1:  cmd.w1 = 1'b1;
      ST_W2:  cmd.w2 = 1'b1;
      ST_ACC: cmd.issue = cnt_r < ACC_PTS;
      ST_X1:  cmd.x1 = 1'b1;
      ST_OUT: cmd.load_out = st.out_free;
      default: cmd.in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

[sv/bpe_dp.sv]
`default_nettype none
module bpe_dp
  import bpe_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  bpe_in_if.sink          in_ch,
  bpe_out_if.source       out_ch,
  input  wire cmd_t       cmd,
  output status_t         st
);
  localparam logic signed [ACC_W-1:0] HALF32 = ACC_W'(64'sd1 <<< 31);

  logic [6:0] level_r;
  logic [6:0] n_c, gi_c, gj_c;
  logic [15:0] vidx_c;
  logic [NUM_W-1:0] num_u, num_v, quo_u, quo_v;
  logic busy_u, busy_v;
  logic [12:0] vidx_r;
  logic cq_r;

  // store, {x, y, z}
  logic [47:0] mem [16];
  logic [47:0] rd_r;

  logic [WT_W-1:0] t_r [2];
  logic [WT_W-1:0] w_r [2];
  logic [33:0] ww_r [2];
  logic [33:0] tt_r [2];
  logic [33:0] wt_r [2];
  logic [WT_W-1:0] bw_r [2][4];
  logic signed [CW_W-1:0] cw_r [2][4];
  logic [WT_W-1:0] bw_nxt [2][4];
  logic signed [CW_W-1:0] cw_nxt [2][4];

  logic [33:0] pp_r;
  logic signed [35:0] pu_r, pv_r;
  logic a_v_r, b_v_r;
  logic signed [50:0] mp_r [3];
  logic signed [51:0] mu_r [3];
  logic signed [51:0] mv_r [3];
  logic signed [ACC_W-1:0] acc_p_r [3];
  logic signed [ACC_W-1:0] acc_u_r [3];
  logic signed [ACC_W-1:0] acc_v_r [3];

  logic signed [TAN_W-1:0] tu_c [3];
  logic signed [TAN_W-1:0] tv_c [3];
  logic signed [47:0] pa_r [3];
  logic signed [47:0] pb_r [3];
  logic signed [15:0] pos_r [3];
  logic signed [15:0] pos_c [3];
  logic signed [NRM_W-1:0] nrm_c [3];

  logic accept;

  assign accept = in_ch.valid && cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;

  assign st.eval_req = in_ch.valid && (in_ch.operation == OP_EVAL);
  assign st.div_busy = busy_u || busy_v;
  assign st.out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_RESET;
    end else if (cfg_we) begin
      level_r <= cfg_wdata;
    end
  end

  // effective level, clamped grid indices, divider numerators and vertex index
  always_comb begin
    if (level_r == '0) begin
      n_c = 7'd1;
    end else if (int'(level_r) > LEVEL_MAX) begin
      n_c = 7'(LEVEL_MAX);
    end else begin
      n_c = level_r;
    end
    gi_c   = (in_ch.grid_i > n_c) ? n_c : in_ch.grid_i;
    gj_c   = (in_ch.grid_j > n_c) ? n_c : in_ch.grid_j;
    num_u  = {gi_c, 16'b0} + NUM_W'(n_c >> 1);
    num_v  = {gj_c, 16'b0} + NUM_W'(n_c >> 1);
    vidx_c = 16'(gi_c) * (16'(n_c) + 16'd1) + 16'(gj_c);
  end

  bpe_div #(.NW(NUM_W), .DW(DEN_W)) u_div_u (
    .clk, .rst_n, .start(cmd.div_go), .num(num_u), .den(n_c), .busy(busy_u), .quo(quo_u)
  );
  bpe_div #(.NW(NUM_W), .DW(DEN_W)) u_div_v (
    .clk, .rst_n, .start(cmd.div_go), .num(num_v), .den(n_c), .busy(busy_v), .quo(quo_v)
  );

  always_ff @(posedge clk) begin
    if (accept && in_ch.operation == OP_LOAD) begin
      mem[in_ch.point_slot] <= {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
    end
    if (cmd.issue) begin
      rd_r <= mem[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      vidx_r <= vidx_c[12:0];
      cq_r   <= (gi_c != '0) && (gj_c != '0);
    end
  end

  // t, w = 1 - t, and the squares and cross term of w and t
  always_ff @(posedge clk) begin
    if (cmd.w1) begin
      t_r[0]  <= quo_u[WT_W-1:0];
      t_r[1]  <= quo_v[WT_W-1:0];
      w_r[0]  <= 17'h10000 - quo_u[WT_W-1:0];
      w_r[1]  <= 17'h10000 - quo_v[WT_W-1:0];
      ww_r[0] <= 34'(17'h10000 - quo_u[WT_W-1:0]) * 34'(17'h10000 - quo_u[WT_W-1:0]);
      ww_r[1] <= 34'(17'h10000 - quo_v[WT_W-1:0]) * 34'(17'h10000 - quo_v[WT_W-1:0]);
      tt_r[0] <= 34'(quo_u[WT_W-1:0]) * 34'(quo_u[WT_W-1:0]);
      tt_r[1] <= 34'(quo_v[WT_W-1:0]) * 34'(quo_v[WT_W-1:0]);
      wt_r[0] <= 34'(17'h10000 - quo_u[WT_W-1:0]) * 34'(quo_u[WT_W-1:0]);
      wt_r[1] <= 34'(17'h10000 - quo_v[WT_W-1:0]) * 34'(quo_v[WT_W-1:0]);
    end
  end

  // cubic weights and derivative coefficients (Du[a-1] - Du[a])
  always_comb begin
    logic [53:0] m;
    logic [34:0] e;
    logic [WT_W-1:0] d0, d1, d2;
    for (int i = 0; i < 2; i++) begin
      m = 54'(ww_r[i]) * 54'(w_r[i]) + 54'(64'd1 << 31);
      bw_nxt[i][0] = m[48:32];
      m = 54'(ww_r[i]) * 54'(t_r[i]);
      m = m + (m << 1) + 54'(64'd1 << 31);
      bw_nxt[i][1] = m[48:32];
      m = 54'(wt_r[i]) * 54'(t_r[i]);
      m = m + (m << 1) + 54'(64'd1 << 31);
      bw_nxt[i][2] = m[48:32];
      m = 54'(tt_r[i]) * 54'(t_r[i]) + 54'(64'd1 << 31);
      bw_nxt[i][3] = m[48:32];
      e  = 35'(ww_r[i]) + 35'd32768;
      d0 = e[32:16];
      e  = (35'(wt_r[i]) << 1) + 35'd32768;
      d1 = e[32:16];
      e  = 35'(tt_r[i]) + 35'd32768;
      d2 = e[32:16];
      cw_nxt[i][0] = -$signed({1'b0, d0});
      cw_nxt[i][1] = $signed({1'b0, d0}) - $signed({1'b0, d1});
      cw_nxt[i][2] = $signed({1'b0, d1}) - $signed({1'b0, d2});
      cw_nxt[i][3] = $signed({1'b0, d2});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.w2) begin
      bw_r <= bw_nxt;
      cw_r <= cw_nxt;
    end
  end

  // term pipeline: weight products, coordinate products, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= cmd.issue;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pp_r <= 34'(bw_r[0][cmd.idx[3:2]]) * 34'(bw_r[1][cmd.idx[1:0]]);
      pu_r <= cw_r[0][cmd.idx[3:2]] * $signed({1'b0, bw_r[1][cmd.idx[1:0]]});
      pv_r <= $signed({1'b0, bw_r[0][cmd.idx[3:2]]}) * cw_r[1][cmd.idx[1:0]];
    end
    if (a_v_r) begin
      for (int c = 0; c < 3; c++) begin
        mp_r[c] <= $signed({1'b0, pp_r}) * $signed(rd_r[47-16*c -: 16]);
        mu_r[c] <= pu_r * $signed(rd_r[47-16*c -: 16]);
        mv_r[c] <= pv_r * $signed(rd_r[47-16*c -: 16]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd.w2) begin
        acc_p_r[c] <= '0;
        acc_u_r[c] <= '0;
        acc_v_r[c] <= '0;
      end else if (b_v_r) begin
        acc_p_r[c] <= acc_p_r[c] + ACC_W'(mp_r[c]);
        acc_u_r[c] <= acc_u_r[c] + ACC_W'(mu_r[c]);
        acc_v_r[c] <= acc_v_r[c] + ACC_W'(mv_r[c]);
      end
    end
  end

  // rounded tangents and rounded, saturated position
  always_comb begin
    logic signed [ACC_W-1:0] s;
    logic signed [TAN_W-1:0] r;
    for (int c = 0; c < 3; c++) begin
      s = acc_u_r[c] + HALF32;
      tu_c[c] = s[55:32];
      s = acc_v_r[c] + HALF32;
      tv_c[c] = s[55:32];
      s = acc_p_r[c] + HALF32;
      r = s[55:32];
      if (r > 24'sd32767) begin
        pos_c[c] = 16'sh7fff;
      end else if (r < -24'sd32768) begin
        pos_c[c] = -16'sd32768;
      end else begin
        pos_c[c] = r[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.x1) begin
      pa_r[0] <= tv_c[1] * tu_c[2];
      pb_r[0] <= tv_c[2] * tu_c[1];
      pa_r[1] <= tv_c[2] * tu_c[0];
      pb_r[1] <= tv_c[0] * tu_c[2];
      pa_r[2] <= tv_c[0] * tu_c[1];
      pb_r[2] <= tv_c[1] * tu_c[0];
      pos_r   <= pos_c;
    end
  end

  always_comb begin
    logic signed [48:0] dn;
    logic signed [48:0] rn;
    for (int c = 0; c < 3; c++) begin
      dn = 49'(pa_r[c]) - 49'(pb_r[c]) + 49'sd2048;
      rn = dn >>> 12;
      if (rn > 49'sd8388607) begin
        nrm_c[c] = 24'sh7fffff;
      end else if (rn < -49'sd8388608) begin
        nrm_c[c] = -24'sd8388608;
      end else begin
        nrm_c[c] = rn[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (cmd.load_out) begin
      out_ch.pos_x        <= pos_r[0];
      out_ch.pos_y        <= pos_r[1];
      out_ch.pos_z        <= pos_r[2];
      out_ch.norm_x       <= nrm_c[0];
      out_ch.norm_y       <= nrm_c[1];
      out_ch.norm_z       <= nrm_c[2];
      out_ch.tex_u        <= t_r[0];
      out_ch.tex_v        <= t_r[1];
      out_ch.vertex_index <= vidx_r;
      out_ch.closes_quad  <= cq_r;
    end
  end
endmodule
`default_nettype wire

[sv/bezier_patch_evaluator_core.sv]
`default_nettype none
// Bicubic Bezier patch evaluator. Load beats (operation 0) write one Q3.12
// control point into slot point_slot and return nothing; a slot must be
// written before any evaluate reads it. Evaluate beats (operation 1) take grid
// indices i, j, form u = i/n and v = j/n (n = level, clamped to 1..LEVEL_MAX,
// indices clamped to n) and return one beat with position, unnormalized
// normal cross(dv, du), tex coords, vertex number i*(n+1)+j and the
// quad-closed flag. An evaluate passes through the bit-serial u/v dividers
// (23 quotient bits plus the done check), the Bernstein weights, a stream of
// the sixteen control points through a three-stage multiply-accumulate pipe
// (one point per cycle from the store), the cross product and the load of the
// output register. The input is taken again once the result sits in the
// output register, even while it waits. The user must write level through
// cfg_we / cfg_wdata only while the block is idle; the block does not enforce
// it. Reset value 12.
module bezier_patch_evaluator_core
  import bpe_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  bpe_in_if.sink          in_ch,
  bpe_out_if.source       out_ch
);
  cmd_t    cmd;
  status_t st;

  // sequencer: accept, divide, weights, accumulate, cross, output
  bpe_ctrl u_ctrl (
    .clk, .rst_n, .st, .cmd
  );

  // store, dividers, MAC pipe and output register
  bpe_dp #(.LEVEL_MAX(LEVEL_MAX)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_ch, .out_ch, .cmd, .st
  );
endmodule
`default_nettype wire

[sv/bpe_checker.sv]
`default_nettype none
module bpe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] tex_u,
  input wire logic [12:0] vertex_index,
  input wire logic        closes_quad
);
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tex_u))
    else $error("stalled result changed");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> tex_u <= 17'h10000)
    else $error("tex_u above 1.0");

  a_edge_no_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tex_u == 17'd0 |-> !closes_quad)
    else $error("quad closed on first grid row");

  a_quad_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && closes_quad |-> vertex_index != 13'd0)
    else $error("quad closed at vertex zero");
endmodule

bind bezier_patch_evaluator_core bpe_checker u_bpe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .tex_u        (out_ch.tex_u),
  .vertex_index (out_ch.vertex_index),
  .closes_quad  (out_ch.closes_quad)
);
`default_nettype wire

[tb/bpe_checker.sv]
`default_nettype none
module bpe_scoreboard
  import bpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  bpe_in_if               in_ch,
  bpe_out_if              out_ch,
  output int              errors,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] px, py, pz;
    logic signed [23:0] nx, ny, nz;
    logic [16:0]        tu, tv;
    logic [12:0]        vidx;
    logic               quad;
  } vertex_t;

  vertex_t            vertex_q[$];
  logic signed [15:0] ctrl_pt[16][3];
  logic [6:0]         tess_level;

  assign pending = vertex_q.size();

  function automatic longint rnd_shr(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_s(longint x, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  // Bernstein weights (cubic) and derivative weights (quadratic), Q0.16
  function automatic void bern(input longint t, output longint b[4], output longint d[3]);
    longint w;
    w = 65536 - t;
    b[0] = (w * w * w + (longint'(1) << 31)) >> 32;
    b[1] = (3 * w * w * t + (longint'(1) << 31)) >> 32;
    b[2] = (3 * w * t * t + (longint'(1) << 31)) >> 32;
    b[3] = (t * t * t + (longint'(1) << 31)) >> 32;
    d[0] = (w * w + 32768) >> 16;
    d[1] = (2 * w * t + 32768) >> 16;
    d[2] = (t * t + 32768) >> 16;
  endfunction

  function automatic vertex_t eval_vertex(longint gi, longint gj);
    vertex_t r;
    longint n, tu, tv, sp, su, sv, p;
    longint bu[4], bv[4], du[3], dv[3];
    longint pos[3], tanu[3], tanv[3], nrm[3];
    n = tess_level;
    if (n == 0) n = 1;
    if (n > LEVEL_MAX_DEF) n = LEVEL_MAX_DEF;
    if (gi > n) gi = n;
    if (gj > n) gj = n;
    tu = (gi * 65536 + n / 2) / n;
    tv = (gj * 65536 + n / 2) / n;
    bern(tu, bu, du);
    bern(tv, bv, dv);
    for (int c = 0; c < 3; c++) begin
      sp = 0; su = 0; sv = 0;
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++) begin
          p = ctrl_pt[a*4+b][c];
          sp += bu[a] * bv[b] * p;
          if (a < 3) su += du[a] * bv[b] * (longint'(ctrl_pt[(a+1)*4+b][c]) - p);
          if (b < 3) sv += bu[a] * dv[b] * (longint'(ctrl_pt[a*4+b+1][c]) - p);
        end
      pos[c]  = clamp_s(rnd_shr(sp, 32), 16);
      tanu[c] = rnd_shr(su, 32);
      tanv[c] = rnd_shr(sv, 32);
    end
    nrm[0] = tanv[1] * tanu[2] - tanv[2] * tanu[1];
    nrm[1] = tanv[2] * tanu[0] - tanv[0] * tanu[2];
    nrm[2] = tanv[0] * tanu[1] - tanv[1] * tanu[0];
    r.px = pos[0]; r.py = pos[1]; r.pz = pos[2];
    r.nx = clamp_s(rnd_shr(nrm[0], 12), 24);
    r.ny = clamp_s(rnd_shr(nrm[1], 12), 24);
    r.nz = clamp_s(rnd_shr(nrm[2], 12), 24);
    r.tu = tu;
    r.tv = tv;
    r.vidx = gi * (n + 1) + gj;
    r.quad = (gi > 0 && gj > 0);
    return r;
  endfunction

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch got %h want %h", $realtime, what, got, want);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      tess_level = LEVEL_RESET;
    end else begin
      if (cfg_we) tess_level = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_LOAD) begin
          ctrl_pt[in_ch.point_slot][0] = in_ch.coord_x;
          ctrl_pt[in_ch.point_slot][1] = in_ch.coord_y;
          ctrl_pt[in_ch.point_slot][2] = in_ch.coord_z;
        end else begin
          vertex_q.insert(vertex_q.size(), eval_vertex(in_ch.grid_i, in_ch.grid_j));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected result beat", $realtime);
          errors++;
        end else begin
          e = vertex_q.pop_front();
          report("pos_x", 24'(out_ch.pos_x), 24'(e.px));
          report("pos_y", 24'(out_ch.pos_y), 24'(e.py));
          report("pos_z", 24'(out_ch.pos_z), 24'(e.pz));
          report("norm_x", out_ch.norm_x, e.nx);
          report("norm_y", out_ch.norm_y, e.ny);
          report("norm_z", out_ch.norm_z, e.nz);
          report("tex_u", 24'(out_ch.tex_u), 24'(e.tu));
          report("tex_v", 24'(out_ch.tex_v), 24'(e.tv));
          report("vertex_index", 24'(out_ch.vertex_index), 24'(e.vidx));
          report("closes_quad", 24'(out_ch.closes_quad), 24'(e.quad));
        end
      end
    end
  end
endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
  import bpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // settle window before cfg writes and at the end
  localparam int SETTLE = 80;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  int         errors;
  int         pending;
  int         tx_idle_pct;  // sender gap chance per beat, percent
  int         rx_idle_pct;  // receiver stall chance per cycle, percent
  logic       rx_hold;      // long receiver hold-off for backpressure

  bpe_in_if  in_ch();
  bpe_out_if out_ch();

  bezier_patch_evaluator_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  bpe_scoreboard u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // receiver: random stalls plus the forced hold-off
  always @(negedge clk) begin
    out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // one input beat; gaps go in front of it, valid stays up across back-to-back beats
  task automatic send_beat(logic op, logic [3:0] slot, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, logic [6:0] gi, logic [6:0] gj);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.point_slot <= slot;
    in_ch.coord_x    <= x;
    in_ch.coord_y    <= y;
    in_ch.coord_z    <= z;
    in_ch.grid_i     <= gi;
    in_ch.grid_j     <= gj;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_pt(logic [3:0] slot, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send_beat(OP_LOAD, slot, x, y, z, 7'($urandom), 7'($urandom));
  endtask

  task automatic eval_at(logic [6:0] gi, logic [6:0] gj);
    send_beat(OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), gi, gj);
  endtask

  // drain: sender idle until every result is back, then let the pipe empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_level(logic [6:0] lvl);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random coordinate, extremes now and then
  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [6:0] lvl;
    int         eff;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rx_hold      = 1'b0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    in_ch.valid  = 1'b0;
    in_ch.operation  = OP_LOAD;
    in_ch.point_slot = '0;
    in_ch.coord_x    = '0;
    in_ch.coord_y    = '0;
    in_ch.coord_z    = '0;
    in_ch.grid_i     = '0;
    in_ch.grid_j     = '0;
    out_ch.ready     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: fill every slot (all slots written before any evaluate),
    // corner coordinates in the first few
    load_pt(4'd0, 16'h8000, 16'h8000, 16'h8000);
    load_pt(4'd5, 16'h7fff, 16'h7fff, 16'h7fff);
    load_pt(4'd10, 16'h8000, 16'h7fff, 16'h0000);
    load_pt(4'd15, 16'h7fff, 16'h8000, 16'hffff);
    for (int s = 0; s < 16; s++)
      if (s != 0 && s != 5 && s != 10 && s != 15)
        load_pt(4'(s), rnd_coord(), rnd_coord(), rnd_coord());
    // reset level 12: corners, an index past the level, the widest index, an interior point
    eval_at(7'd0, 7'd0);
    eval_at(7'd12, 7'd12);
    eval_at(7'd0, 7'd12);
    eval_at(7'd12, 7'd0);
    eval_at(7'd13, 7'd6);
    eval_at(7'd127, 7'd127);
    eval_at(7'd5, 7'd7);
    // level zero behaves as level one, 127 as the maximum
    set_level(7'd0);
    eval_at(7'd1, 7'd0);
    eval_at(7'd1, 7'd1);
    set_level(7'd127);
    eval_at(7'd64, 7'd64);
    eval_at(7'd63, 7'd1);
    eval_at(7'd100, 7'd32);

    // random phases: each pass sets the level, then mostly evaluates with loads mixed in
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       lvl = 7'd1;
        1:       lvl = 7'd64;
        2:       lvl = 7'd0;
        3:       lvl = 7'd127;
        4:       lvl = 7'd3;
        5:       lvl = 7'd12;
        default: lvl = 7'($urandom_range(2, 63));
      endcase
      set_level(lvl);
      if (ph < 3) begin
        tx_idle_pct = 11; rx_idle_pct = 48;
      end else if (ph < 6) begin
        tx_idle_pct = 48; rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      eff = (lvl == 0) ? 1 : (lvl > 64 ? 64 : lvl);
      for (int k = 0; k < 160; k++) begin
        // long receiver hold-off while beats keep coming: fills the block
        if (ph == 1 && k == 20) begin
          fork
            begin
              rx_hold = 1'b1;
              repeat (400) @(negedge clk);
              rx_hold = 1'b0;
            end
          join_none
        end
        if ($urandom_range(0, 99) < 15)
          load_pt(4'($urandom), rnd_coord(), rnd_coord(), rnd_coord());
        else if ($urandom_range(0, 9) == 0)
          eval_at(7'($urandom), 7'($urandom));  // includes indices past the level
        else
          eval_at(7'($urandom_range(0, eff)), 7'($urandom_range(0, eff)));
      end
    end

    drain();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

[bezier_patch_evaluator_core.f]
sv/bpe_pkg.sv
sv/bpe_if.sv
sv/bpe_div.sv
sv/bpe_ctrl.sv
sv/bpe_dp.sv
sv/bezier_patch_evaluator_core.sv
sv/bpe_checker.sv
tb/bpe_checker.sv
tb/testbench.sv
